FILE: rtl/core/lmds_pkg.sv
package lmds_pkg;

    // Fixed geometry of the multiplexed matrix
    localparam int DOT_COUNT = 25;
    localparam int ROW_COUNT = 3;
    localparam int ROW_W     = 2;
    localparam int COL_W     = 9;
    localparam int DOT_W     = 16;
    localparam int FUNC_W    = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_DOT_ON  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DOT_OFF = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

    // Last row of the scan, after which it wraps to the first
    localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;
    localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;

    // Where one dot sits in the matrix
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] mask;
    } t_dot_map;

    // Update towards the frame store, one transaction per fire
    typedef struct packed {
        logic              fire;
        logic [FUNC_W-1:0] func;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  mask;
    } t_upd;

    // Dot number to row and column bit
    localparam t_dot_map DOT_MAP [DOT_COUNT] = '{
        '{2'd0, 9'h001}, '{2'd1, 9'h008}, '{2'd0, 9'h002}, '{2'd1, 9'h010}, '{2'd0, 9'h004},
        '{2'd2, 9'h008}, '{2'd2, 9'h010}, '{2'd2, 9'h020}, '{2'd2, 9'h040}, '{2'd2, 9'h080},
        '{2'd1, 9'h002}, '{2'd0, 9'h100}, '{2'd1, 9'h004}, '{2'd2, 9'h100}, '{2'd1, 9'h001},
        '{2'd0, 9'h080}, '{2'd0, 9'h040}, '{2'd0, 9'h020}, '{2'd0, 9'h010}, '{2'd0, 9'h008},
        '{2'd2, 9'h004}, '{2'd1, 9'h040}, '{2'd2, 9'h001}, '{2'd1, 9'h020}, '{2'd2, 9'h002}
    };

endpackage

FILE: rtl/core/led_matrix_dot_scanner_unit.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | i_in_valid/o_in_stall | i_func, i_dot_number
// out     | output    | o_out_valid/i_out_stall | o_row_drive, o_column_drive
//
// One item per cycle unless stalled. An item waits in the input register,
// where the dot number is reduced; as it leaves, the frame store is updated
// or the scan advanced; a tick's result is in the result register next cycle.
// Reset clears the frame store, the scan row and both valid flags.
// A stalled result holds; a tick then waits in the input register and stalls
// the input, while dot updates go on as long as no tick waits ahead of them.
module led_matrix_dot_scanner_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [lmds_pkg::FUNC_W-1:0]     i_func,
    input  logic [lmds_pkg::DOT_W-1:0]      i_dot_number,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lmds_pkg::ROW_COUNT-1:0]  o_row_drive,
    output logic [lmds_pkg::COL_W-1:0]      o_column_drive
);
    import lmds_pkg::*;

    logic              r_s1_valid;
    logic [FUNC_W-1:0] r_func;
    logic [DOT_W-1:0]  r_dot;
    t_dot_map          map;
    t_upd              upd;
    logic              out_free;
    logic              s1_fire;
    logic              in_accept;

    // Stage 1 fires unless it holds a tick and the result slot is blocked
    assign out_free   = !o_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && ((r_func != FUNC_TICK) || out_free);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept || (r_s1_valid && !s1_fire);
            if (in_accept) begin
                r_func <= i_func;
                r_dot  <= i_dot_number;
            end
        end
    end

    lmds_dot_decode u_decode (
        .i_dot_number (r_dot),
        .o_map        (map)
    );

    assign upd.fire = s1_fire;
    assign upd.func = r_func;
    assign upd.row  = map.row;
    assign upd.mask = map.mask;

    lmds_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_upd          (upd),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_row_drive    (o_row_drive),
        .o_column_drive (o_column_drive)
    );

endmodule

FILE: rtl/core/lmds_dot_decode.sv
module lmds_dot_decode (
    input  logic [lmds_pkg::DOT_W-1:0] i_dot_number,
    output lmds_pkg::t_dot_map         o_map
);
    import lmds_pkg::*;

    logic [5:0]  hi;
    logic [10:0] folded;
    logic [10:0] m;

    // 1024 is -1 modulo 25, so x = hi*1024 + lo folds to lo - hi (+75 keeps it positive)
    assign hi     = i_dot_number[15:10];
    assign folded = {1'b0, i_dot_number[9:0]} + 11'd75 - {5'b0, hi};

    // Conditional subtract chain, result below 25
    always_comb begin
        m = folded;
        if (m >= 11'd800) m = m - 11'd800;
        if (m >= 11'd400) m = m - 11'd400;
        if (m >= 11'd200) m = m - 11'd200;
        if (m >= 11'd100) m = m - 11'd100;
        if (m >= 11'd50)  m = m - 11'd50;
        if (m >= 11'd25)  m = m - 11'd25;
    end

    assign o_map = DOT_MAP[m[4:0]];

endmodule

FILE: rtl/core/lmds_frame.sv
module lmds_frame (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lmds_pkg::t_upd             i_upd,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic [lmds_pkg::ROW_COUNT-1:0] o_row_drive,
    output logic [lmds_pkg::COL_W-1:0] o_column_drive
);
    import lmds_pkg::*;

    logic [COL_W-1:0] r_frame [ROW_COUNT];
    logic [COL_W-1:0] n_frame [ROW_COUNT];
    logic [ROW_W-1:0] r_scan_row;
    logic [ROW_W-1:0] n_scan_row;
    logic [COL_W-1:0] shown;
    logic             is_tick;

    assign is_tick = i_upd.fire && (i_upd.func == FUNC_TICK);

    // Per-row set or clear of the addressed column bit
    always_comb begin
        for (int r = 0; r < ROW_COUNT; r++) begin
            n_frame[r] = r_frame[r];
            if (i_upd.fire && (i_upd.row == r[ROW_W-1:0])) begin
                case (i_upd.func)
                    FUNC_DOT_ON:  n_frame[r] = r_frame[r] | i_upd.mask;
                    FUNC_DOT_OFF: n_frame[r] = r_frame[r] & ~i_upd.mask;
                    default:      n_frame[r] = r_frame[r];
                endcase
            end
        end
    end

    // Scan advance with wrap after the last row
    always_comb begin
        n_scan_row = (r_scan_row == ROW_LAST) ? ROW_FIRST : r_scan_row + 2'd1;
        case (n_scan_row)
            2'd0:    shown = r_frame[0];
            2'd1:    shown = r_frame[1];
            default: shown = r_frame[2];
        endcase
    end

    // Frame store, scan row and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROW_COUNT; r++) r_frame[r] <= '0;
            r_scan_row  <= ROW_FIRST;
            o_out_valid <= 1'b0;
        end else begin
            for (int r = 0; r < ROW_COUNT; r++) r_frame[r] <= n_frame[r];
            if (is_tick) begin
                r_scan_row     <= n_scan_row;
                o_out_valid    <= 1'b1;
                o_row_drive    <= 3'b001 << n_scan_row;
                o_column_drive <= ~shown;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/lmds_checker.sv
module lmds_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [lmds_pkg::ROW_COUNT-1:0]  o_row_drive,
    input logic [lmds_pkg::COL_W-1:0]      o_column_drive
);
    import lmds_pkg::*;

    // Reset leaves no result pending and the input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall left after reset");

    // Input only backs up behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // Exactly one row driven per result
    a_row_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_row_drive))
        else $error("row drive not one-hot");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_row_drive) && $stable(o_column_drive))
        else $error("stalled result changed");

endmodule

bind led_matrix_dot_scanner_unit lmds_checker u_lmds_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_row_drive    (o_row_drive),
    .o_column_drive (o_column_drive)
);

FILE: tb/led_matrix_dot_scanner_unit_test.sv
`timescale 1ns / 1ps

module led_matrix_dot_scanner_unit_test;
    import lmds_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;

    // Row and column bit of each dot, as wired on the board
    localparam logic [ROW_W-1:0] DOT_ROW [DOT_COUNT] = '{
        2'd0, 2'd1, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd0, 2'd1, 2'd2, 2'd1,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd2, 2'd1, 2'd2, 2'd1, 2'd2
    };
    localparam logic [COL_W-1:0] DOT_COL [DOT_COUNT] = '{
        9'd1,   9'd8,   9'd2,   9'd16,  9'd4,
        9'd8,   9'd16,  9'd32,  9'd64,  9'd128,
        9'd2,   9'd256, 9'd4,   9'd256, 9'd1,
        9'd128, 9'd64,  9'd32,  9'd16,  9'd8,
        9'd4,   9'd64,  9'd1,   9'd32,  9'd2
    };

    // Unused operation code, must be ignored by the block
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [ROW_COUNT-1:0] row_drive;
        logic [COL_W-1:0]     column_drive;
    } t_drive;

    // Frame store and scan position mirrored here; one queued drive per tick
    class matrix_scoreboard;
        logic [COL_W-1:0] lit_cols [ROW_COUNT];
        logic [ROW_W-1:0] shown_row;
        t_drive           expected_drives [$];
        int unsigned      errors;

        function new();
            for (int r = 0; r < ROW_COUNT; r++) lit_cols[r] = '0;
            shown_row = ROW_FIRST;
            errors    = 0;
        endfunction

        function void note_input(logic [FUNC_W-1:0] func, logic [DOT_W-1:0] dot_number);
            int unsigned      dot;
            logic [ROW_W-1:0] row;
            logic [COL_W-1:0] col;
            t_drive           drive;
            dot = dot_number % DOT_COUNT;
            row = DOT_ROW[dot];
            col = DOT_COL[dot];
            case (func)
                FUNC_DOT_ON: begin
                    lit_cols[row] = lit_cols[row] | col;
                end
                FUNC_DOT_OFF: begin
                    lit_cols[row] = lit_cols[row] & ~col;
                end
                FUNC_TICK: begin
                    // scan wraps from the last row to the first
                    shown_row = (shown_row >= ROW_LAST) ? ROW_FIRST : shown_row + 2'd1;
                    drive.row_drive    = 3'b001 << shown_row;
                    drive.column_drive = ~lit_cols[shown_row];
                    expected_drives.push_back(drive);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [ROW_COUNT-1:0] row_drive,
                                   logic [COL_W-1:0] column_drive);
            t_drive want;
            if (expected_drives.size() == 0) begin
                $display("%0t: unexpected result row %h column %h", $time,
                         row_drive, column_drive);
                errors++;
                return;
            end
            want = expected_drives.pop_front();
            if (row_drive !== want.row_drive) begin
                $display("%0t: row_drive expected %h actual %h", $time,
                         want.row_drive, row_drive);
                errors++;
            end
            if (column_drive !== want.column_drive) begin
                $display("%0t: column_drive expected %h actual %h", $time,
                         want.column_drive, column_drive);
                errors++;
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [FUNC_W-1:0]    i_func;
    logic [DOT_W-1:0]     i_dot_number;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [ROW_COUNT-1:0] o_row_drive;
    logic [COL_W-1:0]     o_column_drive;

    matrix_scoreboard sb;
    int               send_idle_pct;
    int               recv_idle_pct;
    int unsigned      cycle_count;

    led_matrix_dot_scanner_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_dot_number   (i_dot_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_row_drive    (o_row_drive),
        .o_column_drive (o_column_drive)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure
    initial i_out_stall <= 1'b0;
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_row_drive, o_column_drive);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL led_matrix_dot_scanner_unit");
            $finish;
        end
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [DOT_W-1:0] dot_number);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_dot_number <= dot_number;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(func, dot_number);
    endtask

    // Hold the sender off until every queued drive has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random mix; ignored code 3 transactions are not counted
    task automatic random_run(input int count, input int send_pct, input int recv_pct);
        int               done;
        int               pick;
        logic [FUNC_W-1:0] func;
        logic [DOT_W-1:0]  dot_number;
        done          = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)       func = FUNC_UNUSED;
            else if (pick < 45) func = FUNC_DOT_ON;
            else if (pick < 70) func = FUNC_DOT_OFF;
            else                func = FUNC_TICK;
            if ($urandom_range(0, 3) == 0) dot_number = DOT_W'($urandom_range(0, DOT_COUNT - 1));
            else                           dot_number = DOT_W'($urandom_range(0, 65535));
            send_item(func, dot_number);
            if (func != FUNC_UNUSED) done++;
        end
    endtask

    initial begin
        sb            = new();
        cycle_count   = 0;
        send_idle_pct = 33;
        recv_idle_pct = 54;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_func       <= FUNC_DOT_ON;
        i_dot_number <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first tick on a blank frame, field extremes, wrap, unused code
        send_item(FUNC_TICK,    16'd0);
        send_item(FUNC_DOT_ON,  16'd0);
        send_item(FUNC_DOT_ON,  16'hFFFF);
        send_item(FUNC_DOT_ON,  16'd24);
        send_item(FUNC_DOT_ON,  16'd25);
        send_item(FUNC_TICK,    16'hFFFF);
        send_item(FUNC_TICK,    16'd0);
        send_item(FUNC_TICK,    16'd0);
        send_item(FUNC_UNUSED,  16'hFFFF);
        send_item(FUNC_TICK,    16'd0);
        send_item(FUNC_DOT_OFF, 16'd0);
        send_item(FUNC_DOT_OFF, 16'hFFFF);
        send_item(FUNC_DOT_ON,  16'd13);
        send_item(FUNC_DOT_ON,  16'd11);
        send_item(FUNC_DOT_ON,  16'hFFFE);
        send_item(FUNC_TICK,    16'd0);
        send_item(FUNC_TICK,    16'd0);
        send_item(FUNC_TICK,    16'd0);
        send_item(FUNC_UNUSED,  16'd0);
        send_item(FUNC_DOT_OFF, 16'd24);
        send_item(FUNC_TICK,    16'd0);
        drain();

        random_run(633, 33, 54);
        random_run(633, 54, 33);
        random_run(634, 0, 0);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected drives never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("PASS led_matrix_dot_scanner_unit");
        end else begin
            $display("FAIL led_matrix_dot_scanner_unit");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/lmds_pkg.sv
rtl/core/lmds_dot_decode.sv
rtl/core/lmds_frame.sv
rtl/core/led_matrix_dot_scanner_unit.sv
rtl/core/lmds_checker.sv
tb/led_matrix_dot_scanner_unit_test.sv
